// ----- rtl/ctrng_pkg.sv -----
// ----------------------------------------------------------------------------
// ctrng_pkg
// Shared types, constants and step functions for the combined Tausworthe
// range generator.
// ----------------------------------------------------------------------------
package ctrng_pkg;

   localparam logic [31:0] MASK_A     = 32'hFFFF_FFFE;
   localparam logic [31:0] MASK_B     = 32'hFFFF_FFF8;
   localparam logic [31:0] MASK_C     = 32'hFFFF_FFF0;
   localparam logic [31:0] SEED_MIX_A = 32'hFEA0_9B9D;
   localparam logic [31:0] SEED_MIX_B = 32'h9C12_9511;
   localparam logic [31:0] SEED_MIX_C = 32'h2512_CFB8;

   localparam logic FUNC_DRAW   = 1'b0;
   localparam logic FUNC_RESEED = 1'b1;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } comp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] lo;
      logic [31:0] span;
      logic [31:0] raw;
   } stage_type;

   function automatic comp_type advance(input comp_type s);
      comp_type n;
      n.a = ((s.a & MASK_A) << 24) ^ (((s.a << 7) ^ s.a) >> 7);
      n.b = ((s.b & MASK_B) << 7) ^ (((s.b << 2) ^ s.b) >> 22);
      n.c = ((s.c & MASK_C) << 11) ^ (((s.c << 9) ^ s.c) >> 17);
      return n;
   endfunction

   function automatic comp_type reseed(input logic [31:0] seed);
      comp_type s;
      s.a = (seed ^ SEED_MIX_A) & MASK_A;
      s.b = (seed ^ SEED_MIX_B) & MASK_B;
      s.c = (seed ^ SEED_MIX_C) & MASK_C;
      s.a = s.a ^ (((s.a << 7) ^ s.a) >> 31);
      s.b = s.b ^ (((s.b << 2) ^ s.b) >> 29);
      s.c = s.c ^ (((s.c << 9) ^ s.c) >> 28);
      return advance(s);
   endfunction

   function automatic logic [31:0] mix(input comp_type s);
      return s.a ^ s.b ^ s.c;
   endfunction

endpackage

// ----- rtl/combined_tausworthe_range_rng_core.sv -----
// ----------------------------------------------------------------------------
// combined_tausworthe_range_rng_core
// Three-component Tausworthe generator with ranged output.
//
//  channel  dir  beat contents
//  req      in   tuser: func; tdata: seed_word, bound_low, bound_high
//  rsp      out  tdata: ranged_value, raw_word (draw beats only)
//
// One beat per cycle sustained while rsp is not stalled; a draw result is
// registered in the stage register, then in the output register. The state
// steps in the accept cycle; the multiply sits between the two registers.
// Reset (synchronous) loads the state as a reseed with seed 0 and empties
// the pipeline. A stalled rsp holds req only once both stages are full.
// ----------------------------------------------------------------------------
module combined_tausworthe_range_rng_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // [0] func
   input  logic [95:0] req_tdata,   // [31:0] seed_word, [63:32] bound_low,
                                    // [95:64] bound_high
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [31:0] ranged_value, [63:32] raw_word
);

   ctrng_pkg::stage_type stage_ff;
   ctrng_pkg::stage_type stage_in;
   logic                 stage_ready;
   logic                 accept;
   logic [31:0]          raw_next;
   logic [31:0]          b0;
   logic [31:0]          b1;
   logic [31:0]          ranged_value;
   logic [31:0]          raw_word;

   assign b0         = req_tdata[63:32];
   assign b1         = req_tdata[95:64];
   assign req_tready = !stage_ff.valid || stage_ready;
   assign accept     = req_tvalid && req_tready;

   ctrng_state u_state (
      .clock     (clock),
      .reset     (reset),
      .step_en   (accept),
      .func      (req_tuser[0]),
      .seed_word (req_tdata[31:0]),
      .raw_next  (raw_next)
   );

   always_comb begin
      stage_in.valid = accept && (req_tuser[0] == ctrng_pkg::FUNC_DRAW);
      stage_in.raw   = raw_next;
      if (b0 > b1) begin
         stage_in.lo   = b1;
         stage_in.span = b0 - b1;
      end else begin
         stage_in.lo   = b0;
         stage_in.span = b1 - b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (req_tready) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (stage_in.valid) begin
         stage_ff.lo   <= stage_in.lo;
         stage_ff.span <= stage_in.span;
         stage_ff.raw  <= stage_in.raw;
      end
   end

   ctrng_scale u_scale (
      .clock        (clock),
      .reset        (reset),
      .stage        (stage_ff),
      .stage_ready  (stage_ready),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .ranged_value (ranged_value),
      .raw_word     (raw_word)
   );

   assign rsp_tdata = {raw_word, ranged_value};

endmodule

// ----- rtl/ctrng_state.sv -----
// ----------------------------------------------------------------------------
// ctrng_state
// Component registers; steps them on a draw beat, reloads them on a reseed
// beat and presents the raw word of the updated state.
// ----------------------------------------------------------------------------
module ctrng_state (
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  logic        func,
   input  logic [31:0] seed_word,
   output logic [31:0] raw_next
);

   ctrng_pkg::comp_type comp_ff;
   ctrng_pkg::comp_type comp_in;
   ctrng_pkg::comp_type comp_step;

   always_comb begin
      comp_step = ctrng_pkg::advance(comp_ff);
      comp_in   = comp_ff;
      if (step_en) begin
         if (func == ctrng_pkg::FUNC_RESEED) begin
            comp_in = ctrng_pkg::reseed(seed_word);
         end else begin
            comp_in = comp_step;
         end
      end
   end

   assign raw_next = ctrng_pkg::mix(comp_step);

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_ff <= ctrng_pkg::reseed(32'h0000_0000);
      end else begin
         comp_ff <= comp_in;
      end
   end

endmodule

// ----- rtl/ctrng_scale.sv -----
// ----------------------------------------------------------------------------
// ctrng_scale
// Output stage: scales the raw word into the range with a 32x32 multiply
// and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module ctrng_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrng_pkg::stage_type  stage,
   output logic                  stage_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [31:0]           ranged_value,
   output logic [31:0]           raw_word
);

   logic        valid_ff;
   logic [31:0] ranged_ff;
   logic [31:0] raw_ff;
   logic [63:0] product;
   logic [31:0] ranged_in;
   logic        load;

   assign stage_ready = !valid_ff || out_ready;
   assign load        = stage_ready && stage.valid;
   assign product     = {32'h0, stage.span} * {32'h0, stage.raw};
   assign ranged_in   = stage.lo + product[63:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_ready) begin
         valid_ff <= stage.valid;
      end
      if (load) begin
         ranged_ff <= ranged_in;
         raw_ff    <= stage.raw;
      end
   end

   assign out_valid    = valid_ff;
   assign ranged_value = ranged_ff;
   assign raw_word     = raw_ff;

endmodule

// ----- rtl/ctrng_checker.sv -----
// ----------------------------------------------------------------------------
// ctrng_checker
// Port-level checks for the range generator, bound to the top level.
// ----------------------------------------------------------------------------
module ctrng_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty output");

   a_draw_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == ctrng_pkg::FUNC_DRAW)
      |-> ##2 rsp_tvalid)
      else $error("draw beat produced no result");

endmodule

bind combined_tausworthe_range_rng_core ctrng_checker u_ctrng_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- bench/tb_combined_tausworthe_range_rng_core.sv -----
// ----------------------------------------------------------------------------
// tb_combined_tausworthe_range_rng_core
// Self-checking bench for the three-component Tausworthe range generator.
// A directed table covers bound extremes, reversed and equal bounds, and
// reseeds. A random stream of draws and reseeds follows. Every draw beat is
// predicted from an independent model of the component registers. Each rsp
// beat is compared field by field against the oldest prediction. Both
// channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_combined_tausworthe_range_rng_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 530;
   localparam int QUIET_TAIL   = 60;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [31:0] raw;
      logic [31:0] ranged;
   } draw_result_type;

   typedef struct {
      logic        func;
      logic [31:0] seed;
      logic [31:0] bound_a;
      logic [31:0] bound_b;
      logic        pinned;
      logic [31:0] pinned_value;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [0:0]  req_tuser = '0;    // [0] func
   logic [95:0] req_tdata = '0;    // [31:0] seed_word, [63:32] bound_low, [95:64] bound_high
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [31:0] ranged_value, [63:32] raw_word

   logic [31:0] gen_a, gen_b, gen_c;
   draw_result_type pending_draws[$];
   stim_row_type    directed_rows[$];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  quiet_tail = 1'b0;
   bit  rx_calm = 1'b0;
   int  rx_stall_left = 0;

   combined_tausworthe_range_rng_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---- generator model ----
   function automatic logic [31:0] taus_next(input logic [31:0] s, input logic [31:0] mask,
                                             input int shl, input int fb, input int shr);
      return ((s & mask) << shl) ^ (((s << fb) ^ s) >> shr);
   endfunction

   function automatic logic [31:0] seed_fold(input logic [31:0] seed, input logic [31:0] mix_k,
                                             input logic [31:0] mask, input int fb,
                                             input int shr);
      logic [31:0] s;
      s = (seed ^ mix_k) & mask;
      return s ^ (((s << fb) ^ s) >> shr);
   endfunction

   task automatic advance_generators(output logic [31:0] raw);
      gen_a = taus_next(gen_a, ctrng_pkg::MASK_A, 24, 7, 7);
      gen_b = taus_next(gen_b, ctrng_pkg::MASK_B, 7, 2, 22);
      gen_c = taus_next(gen_c, ctrng_pkg::MASK_C, 11, 9, 17);
      raw = gen_a ^ gen_b ^ gen_c;
   endtask

   task automatic load_seed(input logic [31:0] seed);
      logic [31:0] discard;
      gen_a = seed_fold(seed, ctrng_pkg::SEED_MIX_A, ctrng_pkg::MASK_A, 7, 31);
      gen_b = seed_fold(seed, ctrng_pkg::SEED_MIX_B, ctrng_pkg::MASK_B, 2, 29);
      gen_c = seed_fold(seed, ctrng_pkg::SEED_MIX_C, ctrng_pkg::MASK_C, 9, 28);
      advance_generators(discard);
   endtask

   task automatic predict_beat(input logic func, input logic [31:0] seed,
                               input logic [31:0] bound_a, input logic [31:0] bound_b,
                               input logic pinned, input logic [31:0] pinned_value);
      logic [31:0] lo, hi, raw;
      logic [63:0] product;
      draw_result_type res;
      if (func == ctrng_pkg::FUNC_RESEED) begin
         load_seed(seed);
      end else begin
         lo = (bound_a > bound_b) ? bound_b : bound_a;
         hi = (bound_a > bound_b) ? bound_a : bound_b;
         advance_generators(raw);
         product = {32'd0, hi - lo} * {32'd0, raw};
         res.raw = raw;
         res.ranged = pinned ? pinned_value : lo + product[63:32];
         pending_draws.push_back(res);
      end
   endtask

   // ---- request side ----
   task automatic send_beat(input logic func, input logic [31:0] seed,
                            input logic [31:0] bound_a, input logic [31:0] bound_b,
                            input logic pinned, input logic [31:0] pinned_value);
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {bound_b, bound_a, seed};
      do @(posedge clock); while (!req_tready);
      predict_beat(func, seed, bound_a, bound_b, pinned, pinned_value);
   endtask

   task automatic add_row(input logic func, input logic [31:0] seed, input logic [31:0] bound_a,
                          input logic [31:0] bound_b, input logic pinned,
                          input logic [31:0] pinned_value);
      stim_row_type r;
      r.func = func;
      r.seed = seed;
      r.bound_a = bound_a;
      r.bound_b = bound_b;
      r.pinned = pinned;
      r.pinned_value = pinned_value;
      directed_rows.push_back(r);
   endtask

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'hFFFF_FFFE;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   task automatic idle_after_beat(input bit calm);
      if (!quiet_tail && !calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // ---- response side ----
   always @(posedge clock) begin
      if (cycle_count % 64 == 0)
         rx_calm <= ($urandom_range(0, 3) == 0);
      if (quiet_tail || reset) begin
         rsp_tready <= 1'b1;
         rx_stall_left <= 0;
      end else if (rx_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rx_stall_left <= rx_stall_left - 1;
      end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         rx_stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      draw_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_draws.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected rsp beat: ranged %h raw %h", rsp_tdata[31:0],
                        rsp_tdata[63:32]);
         end else begin
            want = pending_draws.pop_front();
            if (rsp_tdata[31:0] !== want.ranged || rsp_tdata[63:32] !== want.raw) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("rsp mismatch: ranged exp %h got %h, raw exp %h got %h",
                           want.ranged, rsp_tdata[31:0], want.raw, rsp_tdata[63:32]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("combined_tausworthe_range_rng_core regression: fail");
         $finish;
      end
   end

   // ---- stimulus ----
   initial begin
      logic        func;
      logic [31:0] seed, bound_a, bound_b;
      bit          tx_calm;

      load_seed(32'd0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      add_row(ctrng_pkg::FUNC_DRAW,   32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0);
      add_row(ctrng_pkg::FUNC_DRAW,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0);
      add_row(ctrng_pkg::FUNC_DRAW,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
              32'h0000_0000);
      add_row(ctrng_pkg::FUNC_DRAW,   32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              32'hFFFF_FFFF);
      add_row(ctrng_pkg::FUNC_DRAW,   32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1,
              32'h0000_0000);
      add_row(ctrng_pkg::FUNC_DRAW,   32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1,
              32'hFFFF_FFFE);
      add_row(ctrng_pkg::FUNC_DRAW,   32'h0000_0000, 32'h0000_0064, 32'h0000_000A, 1'b0, '0);
      add_row(ctrng_pkg::FUNC_RESEED, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
      add_row(ctrng_pkg::FUNC_DRAW,   32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0);
      add_row(ctrng_pkg::FUNC_RESEED, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, '0);
      add_row(ctrng_pkg::FUNC_DRAW,   32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0);
      add_row(ctrng_pkg::FUNC_RESEED, 32'hA5A5_A5A5, 32'h1234_5678, 32'h8765_4321, 1'b0, '0);
      add_row(ctrng_pkg::FUNC_DRAW,   32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0);
      add_row(ctrng_pkg::FUNC_RESEED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0);
      add_row(ctrng_pkg::FUNC_RESEED, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000, 1'b0, '0);
      add_row(ctrng_pkg::FUNC_DRAW,   32'h5A5A_5A5A, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b1,
              32'hDEAD_BEEF);
      add_row(ctrng_pkg::FUNC_DRAW,   32'h0000_0000, 32'h0000_03E8, 32'h0000_07D0, 1'b0, '0);
      add_row(ctrng_pkg::FUNC_DRAW,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_FFFF, 1'b0, '0);
      add_row(ctrng_pkg::FUNC_DRAW,   32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0);
      add_row(ctrng_pkg::FUNC_DRAW,   32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, '0);

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].func, directed_rows[i].seed, directed_rows[i].bound_a,
                   directed_rows[i].bound_b, directed_rows[i].pinned,
                   directed_rows[i].pinned_value);
         idle_after_beat(1'b0);
      end

      tx_calm = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0)
            tx_calm = ($urandom_range(0, 2) == 0);
         if (n == RANDOM_ITEMS - QUIET_TAIL)
            quiet_tail = 1'b1;
         func = ($urandom_range(0, 11) == 0) ? ctrng_pkg::FUNC_RESEED : ctrng_pkg::FUNC_DRAW;
         seed = $urandom;
         case ($urandom_range(0, 5))
            0: begin
               bound_a = $urandom;
               bound_b = $urandom;
            end
            1: begin
               bound_a = $urandom;
               bound_b = bound_a + $urandom_range(0, 15);
            end
            2: begin
               bound_a = $urandom;
               bound_b = bound_a;
            end
            3: begin
               bound_a = pick_extreme();
               bound_b = pick_extreme();
            end
            4: begin
               bound_a = pick_extreme();
               bound_b = $urandom;
            end
            default: begin
               bound_b = $urandom_range(0, 32'h7FFF_FFFF);
               bound_a = bound_b | 32'h8000_0000;
            end
         endcase
         send_beat(func, seed, bound_a, bound_b, 1'b0, '0);
         if (n == RANDOM_ITEMS / 2) begin
            // hold off until the response side has drained
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_draws.size() != 0) @(posedge clock);
         end else begin
            idle_after_beat(tx_calm);
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("combined_tausworthe_range_rng_core regression: pass");
      else
         $display("combined_tausworthe_range_rng_core regression: fail");
      $finish;
   end

endmodule
